[design/circle_outline_point_generator_defines.svh]
// ----------------------------------------------------------------------------
// Circle outline point generator: assertion macros
// Shared concurrent assertion helpers for the block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OUTLINE_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_OUTLINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define COG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define COG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[design/cog_pkg.sv]
// ----------------------------------------------------------------------------
// Circle outline point generator package
// Kind codes, back-end sequencer states and status groups.
// ----------------------------------------------------------------------------
package cog_pkg;

    // Request kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ITER,
        BK_DONE
    } cog_back_state_t;

    // Front-end status
    typedef struct packed {
        logic active;
        logic push;
        logic push_last;
    } cog_front_status_t;

    // Back-end status
    typedef struct packed {
        logic pop;
        logic out_load;
    } cog_back_status_t;

endpackage

[design/cog_fifo.sv]
// ----------------------------------------------------------------------------
// Circle outline job queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module cog_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/cog_front.sv]
// ----------------------------------------------------------------------------
// Circle outline front end
// Accepts requests, holds the circle state and issues one job per column.
// ----------------------------------------------------------------------------
module cog_front #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          kind,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0]        radius,
    output logic signed [COORD_BITS-1:0]  job_cx,
    output logic signed [COORD_BITS-1:0]  job_cy,
    output logic signed [RADIUS_BITS:0]   job_off,
    output logic [2*RADIUS_BITS-1:0]      job_rr,
    output logic                          job_last,
    output cog_pkg::cog_front_status_t    status
);

    logic                         active_reg, active_next;
    logic signed [RADIUS_BITS:0]  offset_reg, offset_next;
    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic [RADIUS_BITS-1:0]       radius_reg;
    logic [2*RADIUS_BITS-1:0]     rr_reg;
    logic signed [RADIUS_BITS:0]  last_off;
    logic                         is_last;
    logic                         start;
    logic                         push;

    // Final column sits at radius - 1
    assign last_off = $signed({1'b0, radius_reg}) - $signed((RADIUS_BITS+1)'(1));
    assign is_last  = (offset_reg == last_off);
    assign start    = accept && (kind == cog_pkg::KIND_START);
    assign push     = accept && (kind == cog_pkg::KIND_STEP) && active_reg;

    assign job_cx   = cx_reg;
    assign job_cy   = cy_reg;
    assign job_off  = offset_reg;
    assign job_rr   = rr_reg;
    assign job_last = is_last;

    assign status.active    = active_reg;
    assign status.push      = push;
    assign status.push_last = is_last;

    // Column walk
    always_comb
    begin
        active_next = active_reg;
        offset_next = offset_reg;
        if (start)
        begin
            active_next = (radius != '0);
            offset_next = -$signed({1'b0, radius});
        end
        else if (push)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                offset_next = offset_reg + $signed((RADIUS_BITS+1)'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            offset_reg <= '0;
            radius_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            offset_reg <= offset_next;
            if (start)
            begin
                radius_reg <= radius;
            end
        end
    end

    // Circle parameters and radius squared
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            rr_reg <= radius * radius;
        end
    end

endmodule

[design/cog_back.sv]
// ----------------------------------------------------------------------------
// Circle outline back end
// Iterative integer square root per column and the output register.
// ----------------------------------------------------------------------------
module cog_back #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  logic signed [COORD_BITS-1:0]  job_cx,
    input  logic signed [COORD_BITS-1:0]  job_cy,
    input  logic signed [RADIUS_BITS:0]   job_off,
    input  logic [2*RADIUS_BITS-1:0]      job_rr,
    input  logic                          job_last,
    output logic                          job_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS:0]    point_x,
    output logic signed [COORD_BITS:0]    upper_y,
    output logic signed [COORD_BITS:0]    lower_y,
    output logic                          last,
    output cog_pkg::cog_back_status_t     status
);

    localparam int VW = 2 * RADIUS_BITS;
    localparam int NW = $clog2(RADIUS_BITS);
    localparam int WW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
    localparam int OW = COORD_BITS + 1;
    localparam logic [VW-1:0] TOP_BIT = VW'(1) << (VW - 2);

    cog_pkg::cog_back_state_t state_reg, state_next;

    logic [NW-1:0]                cnt_reg, cnt_next;
    logic [VW-1:0]                rem_reg, rem_next;
    logic [VW-1:0]                res_reg, res_next;
    logic [VW-1:0]                bit_reg, bit_next;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [RADIUS_BITS:0]  off_reg;
    logic                         last_reg;
    logic                         out_valid_reg, out_valid_next;
    logic signed [OW-1:0]         px_reg, up_reg, lo_reg;
    logic                         tlast_reg;

    logic                         out_free;
    logic                         pop;
    logic                         load;
    logic [RADIUS_BITS-1:0]       aoff;
    logic [VW:0]                  trial;

    logic [RADIUS_BITS-1:0]       q;
    logic                         exact;
    logic signed [WW-1:0]         cx_w, cy_w, off_w, q_w;
    logic signed [WW-1:0]         px_w, up_w, lo_w;

    assign out_free = !out_valid_reg || out_ready;
    assign job_pop  = pop;
    assign status.pop      = pop;
    assign status.out_load = load;

    // Magnitude of the column offset and one root step
    assign aoff  = job_off[RADIUS_BITS] ? RADIUS_BITS'(-job_off) : job_off[RADIUS_BITS-1:0];
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    // Output arithmetic with truncation toward zero
    always_comb
    begin
        q     = res_reg[RADIUS_BITS-1:0];
        exact = (rem_reg == '0);
        cx_w  = WW'(cx_reg);
        cy_w  = WW'(cy_reg);
        off_w = WW'(off_reg);
        q_w   = $signed({{(WW-RADIUS_BITS){1'b0}}, q});
        px_w  = cx_w + off_w;
        up_w  = cy_w - q_w;
        lo_w  = cy_w + q_w;
        if (!exact && (cy_w > q_w))
        begin
            up_w = up_w - $signed(WW'(1));
        end
        if (!exact && (lo_w < $signed(WW'(0))))
        begin
            lo_w = lo_w + $signed(WW'(1));
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        load           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cog_pkg::BK_ITER:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next = rem_reg - trial[VW-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = cog_pkg::BK_DONE;
                end
            end
            cog_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cog_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cog_pkg::BK_IDLE;
            end
        endcase

        // Take the next job when idle or as the finished one leaves
        if (job_valid && ((state_reg == cog_pkg::BK_IDLE) || load))
        begin
            pop        = 1'b1;
            state_next = cog_pkg::BK_ITER;
            cnt_next   = NW'(RADIUS_BITS - 1);
            rem_next   = job_rr - aoff * aoff;
            res_next   = '0;
            bit_next   = TOP_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cog_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (pop)
        begin
            cx_reg   <= job_cx;
            cy_reg   <= job_cy;
            off_reg  <= job_off;
            last_reg <= job_last;
        end
        if (load)
        begin
            px_reg    <= px_w[OW-1:0];
            up_reg    <= up_w[OW-1:0];
            lo_reg    <= lo_w[OW-1:0];
            tlast_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign upper_y   = up_reg;
    assign lower_y   = lo_reg;
    assign last      = tlast_reg;

endmodule

[design/circle_outline_point_generator.sv]
// ----------------------------------------------------------------------------
// Circle outline point generator
// Walks the columns of a circle and gives the two outline rows per column.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tuser: kind; tdata: center_x, center_y, radius
//   m_*      out  m_tvalid/m_tready   tdata: point_x, upper_y, lower_y; tlast: last
//
// Each column runs RADIUS_BITS steps of the shared square root unit in the
// back end and then the output load, which is overlapped with the pop of the
// next job. Start requests give no result.
// Reset clears the column walk state, the job queue and the output valid flag.
// Input stalls only when the job queue is full; a waiting result holds the
// back end while the front end keeps filling the queue.
// ----------------------------------------------------------------------------
`include "circle_outline_point_generator_defines.svh"

module circle_outline_point_generator #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_x, center_y, radius (lowest bits first), zero padded
    input  logic [(2*COORD_BITS+RADIUS_BITS+7)/8*8-1:0] s_tdata,
    // kind
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // point_x, upper_y, lower_y (lowest bits first), zero padded
    output logic [(3*(COORD_BITS+1)+7)/8*8-1:0]         m_tdata,
    output logic                   m_tlast
);

    localparam int IN_BITS   = 2 * COORD_BITS + RADIUS_BITS;
    localparam int OW        = COORD_BITS + 1;
    localparam int OUT_BITS  = 3 * OW;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    localparam int JOB_W     = 2 * COORD_BITS + (RADIUS_BITS + 1) + 2 * RADIUS_BITS + 1;
    localparam int Q_DEPTH   = 2;

    logic                          accept;
    logic signed [COORD_BITS-1:0]  f_cx, f_cy, b_cx, b_cy;
    logic signed [RADIUS_BITS:0]   f_off, b_off;
    logic [2*RADIUS_BITS-1:0]      f_rr, b_rr;
    logic                          f_last, b_last;
    logic [JOB_W-1:0]              q_in, q_out;
    logic                          q_full, q_valid;
    logic                          q_pop;
    logic signed [OW-1:0]          point_x, upper_y, lower_y;
    cog_pkg::cog_front_status_t    f_status;
    cog_pkg::cog_back_status_t     b_status;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !q_full;

    cog_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (s_tuser),
        .center_x (s_tdata[COORD_BITS-1:0]),
        .center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .radius   (s_tdata[IN_BITS-1:2*COORD_BITS]),
        .job_cx   (f_cx),
        .job_cy   (f_cy),
        .job_off  (f_off),
        .job_rr   (f_rr),
        .job_last (f_last),
        .status   (f_status)
    );

    // Job packing through the queue
    assign q_in = {f_last, f_rr, f_off, f_cy, f_cx};
    assign {b_last, b_rr, b_off, b_cy, b_cx} = q_out;

    cog_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_status.push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    cog_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_cx    (b_cx),
        .job_cy    (b_cy),
        .job_off   (b_off),
        .job_rr    (b_rr),
        .job_last  (b_last),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .point_x   (point_x),
        .upper_y   (upper_y),
        .lower_y   (lower_y),
        .last      (m_tlast),
        .status    (b_status)
    );

    assign m_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, lower_y, upper_y, point_x};

    // Checks on the queue hand-off and the column walk
    `COG_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, f_status.push, q_valid)
    `COG_ASSERT_NOW(a_pop_needs_job, clk, rst_n, b_status.pop, q_valid)
    `COG_ASSERT_NEXT(a_last_column_ends, clk, rst_n,
        f_status.push && f_status.push_last, !f_status.active)
    `COG_ASSERT_NEXT(a_load_shows_result, clk, rst_n, b_status.out_load, m_tvalid)

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Circle outline point generator testbench
// Drives start and step requests into the block and checks every outline
// point against an in-bench column predictor. Runs a short directed set,
// then random circles under several idle/stall mixes, plus one long
// output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    typedef logic [16:0] coord17_t;

    typedef struct {
        coord17_t point_x;
        coord17_t upper_y;
        coord17_t lower_y;
        logic     last;
    } outline_point_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // center_x, center_y, radius (lowest bits first), zero padded
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // point_x, upper_y, lower_y (lowest bits first), zero padded
    logic        m_tlast;   // last

    // Predictor state
    bit                  gen_active;
    int                  col_offset;
    logic signed [15:0]  held_cx;
    logic signed [15:0]  held_cy;
    logic [10:0]         held_r;

    outline_point_t expected_points[$];
    int             errors;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             stall_cycles_left;

    circle_outline_point_generator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Bit-by-bit floor square root
    function automatic int floor_sqrt(input int unsigned v);
        int unsigned root;
        int unsigned cand;
        root = 0;
        for (int b = 11; b >= 0; b--)
        begin
            cand = root | (32'd1 << b);
            if (cand * cand <= v)
                root = cand;
        end
        return int'(root);
    endfunction

    // Apply one request to the predictor; queue the point it yields
    task automatic advance_outline(input logic kind, input logic signed [15:0] cx,
                                   input logic signed [15:0] cy, input logic [10:0] r,
                                   output bit effective);
        int             aoff;
        int             v;
        int             q;
        int             up;
        int             lo;
        bit             exact;
        outline_point_t pt;
        effective = 1'b0;
        if (kind == cog_pkg::KIND_START)
        begin
            held_cx    = cx;
            held_cy    = cy;
            held_r     = r;
            col_offset = -int'(r);
            gen_active = (r != 11'd0);
            effective  = 1'b1;
        end
        else if (gen_active)
        begin
            aoff  = (col_offset < 0) ? -col_offset : col_offset;
            v     = int'(held_r) * int'(held_r) - aoff * aoff;
            q     = floor_sqrt(v);
            exact = (q * q == v);
            up    = int'(held_cy) - q;
            lo    = int'(held_cy) + q;
            // truncate toward zero when the root is not whole
            if (!exact && int'(held_cy) > q)
                up = up - 1;
            if (!exact && int'(held_cy) < -q)
                lo = lo + 1;
            pt.point_x = coord17_t'(int'(held_cx) + col_offset);
            pt.upper_y = coord17_t'(up);
            pt.lower_y = coord17_t'(lo);
            pt.last    = (col_offset == int'(held_r) - 1);
            expected_points.push_back(pt);
            if (pt.last)
                gen_active = 1'b0;
            else
                col_offset = col_offset + 1;
            effective = 1'b1;
        end
    endtask

    // Send one request; entered and left at a falling edge
    task automatic send_request(input logic kind, input logic signed [15:0] cx,
                                input logic signed [15:0] cy, input logic [10:0] r,
                                output bit effective);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, r, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_outline(kind, cx, cy, r, effective);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'(int'($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Output ready: random stalls, or a counted hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_cycles_left > 0)
            begin
                m_tready <= 1'b0;
                stall_cycles_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input coord17_t want, input coord17_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker
    initial
    begin
        outline_point_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result: actual %h last %b",
                             $time, m_tdata[50:0], m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("point_x", want.point_x, m_tdata[16:0]);
                    check_field("upper_y", want.upper_y, m_tdata[33:17]);
                    check_field("lower_y", want.lower_y, m_tdata[50:34]);
                    check_field("last", coord17_t'(want.last), coord17_t'(m_tlast));
                end
            end
        end
    end

    // Extremes of the fields and the special cases
    task automatic test_directed();
        bit eff;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // step before any circle: ignored
        send_request(cog_pkg::KIND_STEP, 16'sh0000, 16'sh0000, 11'd0, eff);
        // zero radius gives no points
        send_request(cog_pkg::KIND_START, 16'sh1234, 16'sh4321, 11'd0, eff);
        send_request(cog_pkg::KIND_STEP, 16'shffff, 16'shffff, 11'h7ff, eff);
        // radius one at the far corner, then a step past the last column
        send_request(cog_pkg::KIND_START, 16'sh7fff, 16'sh8000, 11'd1, eff);
        repeat (3) send_request(cog_pkg::KIND_STEP, 16'sh0000, 16'sh0000, 11'd0, eff);
        // largest radius from the opposite corner, dropped early
        send_request(cog_pkg::KIND_START, 16'sh8000, 16'sh7fff, 11'h7ff, eff);
        repeat (3) send_request(cog_pkg::KIND_STEP, 16'sh0000, 16'sh0000, 11'd0, eff);
        // centre on zero with inexact roots, dropped by a new start
        send_request(cog_pkg::KIND_START, 16'sh0000, 16'sh0000, 11'd3, eff);
        repeat (4) send_request(cog_pkg::KIND_STEP, 16'sh0000, 16'sh0000, 11'd0, eff);
        send_request(cog_pkg::KIND_START, 16'sh0005, 16'shffff, 11'd3, eff);
        repeat (6) send_request(cog_pkg::KIND_STEP, 16'sh0000, 16'sh0000, 11'd0, eff);
    endtask

    // Mostly whole circles with random content; some noise and cut circles
    task automatic run_random_circles(input int target);
        int done;
        int steps;
        int r;
        bit eff;
        done = 0;
        while (done < target)
        begin
            if ($urandom_range(99) < 10)
            begin
                if ($urandom_range(1))
                    send_request(cog_pkg::KIND_STEP, 16'($urandom), 16'($urandom),
                                 11'($urandom), eff);
                else
                    send_request(cog_pkg::KIND_START, pick_coord(), pick_coord(), 11'd0, eff);
                if (eff)
                    done++;
            end
            else
            begin
                if ($urandom_range(19) == 0)
                begin
                    r     = $urandom_range(2047);
                    steps = $urandom_range(1, 8);
                end
                else
                begin
                    r     = $urandom_range(1, 12);
                    steps = ($urandom_range(9) < 8) ? 2 * r : $urandom_range(0, 2 * r);
                end
                send_request(cog_pkg::KIND_START, pick_coord(), pick_coord(), 11'(r), eff);
                done++;
                repeat (steps)
                begin
                    send_request(cog_pkg::KIND_STEP, 16'($urandom), 16'($urandom),
                                 11'($urandom), eff);
                    if (eff)
                        done++;
                end
                if ($urandom_range(9) == 0)
                    send_request(cog_pkg::KIND_STEP, 16'($urandom), 16'($urandom),
                                 11'($urandom), eff);
            end
        end
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_circles(160);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 48;
        recv_stall_pct = 0;
        run_random_circles(160);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        run_random_circles(160);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_random_circles(160);
    endtask

    // Long output hold-off while step requests keep coming
    task automatic test_backpressure();
        bit eff;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(cog_pkg::KIND_START, 16'sh7fff, pick_coord(), 11'd60, eff);
        stall_cycles_left = 500;
        repeat (120)
            send_request(cog_pkg::KIND_STEP, 16'($urandom), 16'($urandom), 11'($urandom), eff);
    endtask

    // Main sequence
    initial
    begin
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = 1'b0;
        m_tready          = 1'b0;
        errors            = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        stall_cycles_left = 0;
        gen_active        = 1'b0;
        col_offset        = 0;
        held_cx           = '0;
        held_cy           = '0;
        held_r            = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        s_tvalid <= 1'b0;

        // drain, then give the back end time to show any stray result
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (expected_points.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_points.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
